/* hdl/rtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// shared constants, types and the reciprocal table for the rgb to cmyk block
// ----------------------------------------------------------------------------
package rtc_pkg;

   // channel and percentage widths
   localparam int CHAN_W    = 8;
   localparam int PCT_W     = 15;
   localparam int LANES     = 4;
   localparam int RECIP_W   = 23;
   localparam int FRAC_SH   = 8;
   localparam int PROD_W    = CHAN_W + RECIP_W;
   localparam int NUM_W     = 23;
   localparam int REM_W     = CHAN_W + 1;

   // full scale (100 percent with 8 fraction bits) and channel maximum
   localparam logic [PCT_W-1:0]  FULL_SCALE = PCT_W'(25600);
   localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);

   // lane order of the datapath
   localparam int LANE_CYAN    = 0;
   localparam int LANE_MAGENTA = 1;
   localparam int LANE_YELLOW  = 2;
   localparam int LANE_KEY     = 3;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RICH_BLACK_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RICH_CYAN         = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RICH_MAGENTA      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RICH_YELLOW       = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_RICH_KEY          = CSR_IDX_W'(4);

   typedef logic [RECIP_W-1:0] recip_table_type [256];

   // floor(25600 * 256 / d) by shift and subtract, one quotient bit per step
   function automatic logic [RECIP_W-1:0] recip_of(int unsigned d);
      logic [RECIP_W-1:0] num;
      logic [RECIP_W-1:0] quo;
      logic [RECIP_W:0]   rem;
      num = RECIP_W'(25600 * 256);
      quo = '0;
      rem = '0;
      for (int bit_i = RECIP_W - 1; bit_i >= 0; bit_i--) begin
         rem = {rem[RECIP_W-1:0], num[bit_i]};
         if (rem >= (RECIP_W + 1)'(d)) begin
            rem        = rem - (RECIP_W + 1)'(d);
            quo[bit_i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // scaled reciprocal floor(25600 * 256 / d), built at elaboration
   function automatic recip_table_type build_recip_table();
      recip_table_type tbl;
      tbl[0] = '0;
      for (int i = 1; i < 256; i++) begin
         tbl[i] = recip_of(i);
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

/* hdl/rgb_to_cmyk_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cmyk_converter_top
// converts one 8-bit rgb pixel into cmyk percentages with 8 fraction bits
// ----------------------------------------------------------------------------
//  channel  | ports                     | content
//  ---------+---------------------------+------------------------------------
//  request  | req_tvalid/tready/tdata   | one rgb pixel per item
//  response | rsp_tvalid/tready/tdata   | one cmyk result per item
//  config   | csr_we/index/wdata        | rich black enable and values
//
//  an item passes five register stages: s1 to s4 and the result register,
//  which holds it until rsp_tready is high; one item can enter every cycle
//  while no response stall has filled the pipeline. the stage count is set by
//  the reciprocal multiply and the remainder check on the truncated quotient.
//  reset is synchronous: valid bits and config registers clear, rich key to full scale.
//  each stage loads when it is empty or the next stage moves, so a stall on
//  the response side fills bubbles first and loses nothing.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_converter_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cyan_out[14:0], magenta_out[29:15],
                                    // yellow_out[44:30], key_out[59:45], zero fill
   // configuration port
   input  logic                          csr_we,
   input  logic [rtc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtc_pkg::PCT_W-1:0]     csr_wdata
);

   localparam int CW = rtc_pkg::CHAN_W;
   localparam int PW = rtc_pkg::PCT_W;
   localparam int NL = rtc_pkg::LANES;

   // configuration registers
   logic          rich_en_ff;
   logic [PW-1:0] rich_ff [NL];

   always_ff @(posedge clock) begin
      if (reset) begin
         rich_en_ff <= 1'b0;
         rich_ff[rtc_pkg::LANE_CYAN]    <= '0;
         rich_ff[rtc_pkg::LANE_MAGENTA] <= '0;
         rich_ff[rtc_pkg::LANE_YELLOW]  <= '0;
         rich_ff[rtc_pkg::LANE_KEY]     <= rtc_pkg::FULL_SCALE;
      end else if (csr_we) begin
         unique case (csr_index)
            rtc_pkg::CSR_RICH_BLACK_ENABLE: rich_en_ff <= csr_wdata[0];
            rtc_pkg::CSR_RICH_CYAN:         rich_ff[rtc_pkg::LANE_CYAN]    <= csr_wdata;
            rtc_pkg::CSR_RICH_MAGENTA:      rich_ff[rtc_pkg::LANE_MAGENTA] <= csr_wdata;
            rtc_pkg::CSR_RICH_YELLOW:       rich_ff[rtc_pkg::LANE_YELLOW]  <= csr_wdata;
            rtc_pkg::CSR_RICH_KEY:          rich_ff[rtc_pkg::LANE_KEY]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline valid bits and stage enables
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, out_v_ff;
   logic s1_en, s2_en, s3_en, s4_en, out_en;

   assign out_en     = !out_v_ff || rsp_tready;
   assign s4_en      = !s4_v_ff  || out_en;
   assign s3_en      = !s3_v_ff  || s4_en;
   assign s2_en      = !s2_v_ff  || s3_en;
   assign s1_en      = !s1_v_ff  || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_v_ff  <= req_tvalid;
         if (s2_en)  s2_v_ff  <= s1_v_ff;
         if (s3_en)  s3_v_ff  <= s2_v_ff;
         if (s4_en)  s4_v_ff  <= s3_v_ff;
         if (out_en) out_v_ff <= s4_v_ff;
      end
   end

   // stage 1: largest channel, differences per lane, black flag
   logic [CW-1:0] red, green, blue, mx_in;
   logic [CW-1:0] s1_mx_ff;
   logic [CW-1:0] s1_diff_ff [NL];
   logic          s1_zero_ff;

   assign red   = req_tdata[7:0];
   assign green = req_tdata[15:8];
   assign blue  = req_tdata[23:16];

   always_comb begin
      mx_in = red;
      if (green > mx_in) mx_in = green;
      if (blue > mx_in)  mx_in = blue;
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_mx_ff                       <= mx_in;
         s1_diff_ff[rtc_pkg::LANE_CYAN]    <= mx_in - red;
         s1_diff_ff[rtc_pkg::LANE_MAGENTA] <= mx_in - green;
         s1_diff_ff[rtc_pkg::LANE_YELLOW]  <= mx_in - blue;
         s1_diff_ff[rtc_pkg::LANE_KEY]     <= rtc_pkg::CHAN_MAX - mx_in;
         s1_zero_ff                     <= (mx_in == '0);
      end
   end

   // stage 2: reciprocal lookup of the chroma divisor
   logic [CW-1:0]               s2_mx_ff;
   logic [CW-1:0]               s2_diff_ff [NL];
   logic                        s2_zero_ff;
   logic [rtc_pkg::RECIP_W-1:0] s2_recip_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_mx_ff    <= s1_mx_ff;
         s2_diff_ff  <= s1_diff_ff;
         s2_zero_ff  <= s1_zero_ff;
         s2_recip_ff <= rtc_pkg::RECIP_TABLE[s1_mx_ff];
      end
   end

   // stage 3: estimated quotient, at most one below the exact value
   logic [rtc_pkg::PROD_W-1:0] prod [NL];
   logic [CW-1:0]              s3_mx_ff;
   logic [CW-1:0]              s3_diff_ff [NL];
   logic                       s3_zero_ff;
   logic [PW-1:0]              s3_q0_ff [NL];

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         if (i == rtc_pkg::LANE_KEY) begin
            prod[i] = rtc_pkg::PROD_W'(s2_diff_ff[i])
                    * rtc_pkg::PROD_W'(rtc_pkg::RECIP_TABLE[rtc_pkg::CHAN_MAX]);
         end else begin
            prod[i] = rtc_pkg::PROD_W'(s2_diff_ff[i]) * rtc_pkg::PROD_W'(s2_recip_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_mx_ff   <= s2_mx_ff;
         s3_diff_ff <= s2_diff_ff;
         s3_zero_ff <= s2_zero_ff;
         for (int i = 0; i < NL; i++) begin
            s3_q0_ff[i] <= prod[i][rtc_pkg::FRAC_SH +: PW];
         end
      end
   end

   // stage 4: remainder of the estimate against the divisor
   logic [CW-1:0]              div_lane [NL];
   logic [rtc_pkg::NUM_W-1:0]  rem_full [NL];
   logic [CW-1:0]              s4_mx_ff;
   logic                       s4_zero_ff;
   logic [PW-1:0]              s4_q0_ff [NL];
   logic [rtc_pkg::REM_W-1:0]  s4_rem_ff [NL];

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         div_lane[i] = (i == rtc_pkg::LANE_KEY) ? rtc_pkg::CHAN_MAX : s3_mx_ff;
         rem_full[i] = rtc_pkg::NUM_W'(s3_diff_ff[i]) * rtc_pkg::NUM_W'(rtc_pkg::FULL_SCALE)
                     - rtc_pkg::NUM_W'(s3_q0_ff[i]) * rtc_pkg::NUM_W'(div_lane[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_mx_ff   <= s3_mx_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_q0_ff   <= s3_q0_ff;
         for (int i = 0; i < NL; i++) begin
            s4_rem_ff[i] <= rem_full[i][rtc_pkg::REM_W-1:0];
         end
      end
   end

   // stage 5: quotient correction and pure black selection
   logic [CW-1:0] div_fix [NL];
   logic [PW-1:0] q_fix [NL];
   logic [PW-1:0] out_ff [NL];

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         div_fix[i] = (i == rtc_pkg::LANE_KEY) ? rtc_pkg::CHAN_MAX : s4_mx_ff;
         q_fix[i]   = s4_q0_ff[i]
                    + PW'(s4_rem_ff[i] >= rtc_pkg::REM_W'(div_fix[i]));
         if (s4_zero_ff) begin
            if (rich_en_ff) begin
               q_fix[i] = rich_ff[i];
            end else begin
               q_fix[i] = (i == rtc_pkg::LANE_KEY) ? rtc_pkg::FULL_SCALE : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff <= q_fix;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0000,
                        out_ff[rtc_pkg::LANE_KEY],
                        out_ff[rtc_pkg::LANE_YELLOW],
                        out_ff[rtc_pkg::LANE_MAGENTA],
                        out_ff[rtc_pkg::LANE_CYAN]};

`ifndef SYNTHESIS
   // at least one chroma difference is zero: mx is one of the channels
   a_mx_is_channel: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (s1_diff_ff[0] == '0 || s1_diff_ff[1] == '0 || s1_diff_ff[2] == '0))
      else $error("largest channel does not match any input channel");

   // estimated quotient of the cyan and key lanes never exceeds full scale
   a_q0_range: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && !s4_zero_ff) |->
         (s4_q0_ff[0] <= rtc_pkg::FULL_SCALE && s4_q0_ff[3] <= rtc_pkg::FULL_SCALE))
      else $error("quotient estimate above full scale");

   // remainder in the cyan and key lanes stays below twice the divisor, so one correction suffices
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && !s4_zero_ff) |->
         (s4_rem_ff[0] < {s4_mx_ff, 1'b0} && s4_rem_ff[3] < {rtc_pkg::CHAN_MAX, 1'b0}))
      else $error("remainder out of range after reciprocal estimate");

   // an item in the last stage reaches the result register when it moves
   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && out_en) |=> rsp_tvalid)
      else $error("item lost between last stage and result register");
`endif

endmodule

/* dv/rgb_to_cmyk_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cmyk_checker
// Watches the pixel, result and register ports of the rgb to cmyk block.
// Every accepted pixel is converted here with a local copy of the rich black
// registers, and each result is compared in order against that prediction.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_checker
   import rtc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [63:0]          rsp_tdata,   // cyan_out[14:0], magenta_out[29:15],
                                             // yellow_out[44:30], key_out[59:45], zero fill
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PCT_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   pending_count
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [PCT_W-1:0] key;
      logic [PCT_W-1:0] yellow;
      logic [PCT_W-1:0] magenta;
      logic [PCT_W-1:0] cyan;
   } cmyk_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      cmyk_type          cmyk;
   } converted_pixel_type;

   // local copy of the rich black registers
   logic             black_en   = 1'b0;
   logic [PCT_W-1:0] rich_cyan  = '0;
   logic [PCT_W-1:0] rich_mag   = '0;
   logic [PCT_W-1:0] rich_yel   = '0;
   logic [PCT_W-1:0] rich_key   = FULL_SCALE;

   converted_pixel_type expected_cmyk_q[$];
   int errors       = 0;
   int results_seen = 0;

   // one chroma lane: floor((mx - ch) * 100% / mx)
   function automatic logic [PCT_W-1:0] chroma_pct(int unsigned mx, logic [CHAN_W-1:0] ch);
      int unsigned q;
      q = ((mx - ch) * FULL_SCALE) / mx;
      return PCT_W'(q);
   endfunction

   // cmyk conversion of one pixel under the current register copy
   function automatic cmyk_type predict_cmyk(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                             logic [CHAN_W-1:0] b);
      int unsigned mx;
      cmyk_type    res;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (mx == 0) begin
         // pure black: no division, rich black or plain full key
         if (black_en) begin
            res.cyan    = rich_cyan;
            res.magenta = rich_mag;
            res.yellow  = rich_yel;
            res.key     = rich_key;
         end else begin
            res.cyan    = '0;
            res.magenta = '0;
            res.yellow  = '0;
            res.key     = FULL_SCALE;
         end
      end else begin
         res.key     = PCT_W'(((CHAN_MAX - mx) * FULL_SCALE) / CHAN_MAX);
         res.cyan    = chroma_pct(mx, r);
         res.magenta = chroma_pct(mx, g);
         res.yellow  = chroma_pct(mx, b);
      end
      return res;
   endfunction

   // register tracking, prediction on accept, comparison on result
   always @(posedge clock) begin
      converted_pixel_type item;
      converted_pixel_type exp_item;
      cmyk_type            got;
      logic [3:0]          fill;
      if (reset) begin
         black_en  = 1'b0;
         rich_cyan = '0;
         rich_mag  = '0;
         rich_yel  = '0;
         rich_key  = FULL_SCALE;
         expected_cmyk_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RICH_BLACK_ENABLE: black_en  = csr_wdata[0];
               CSR_RICH_CYAN:         rich_cyan = csr_wdata;
               CSR_RICH_MAGENTA:      rich_mag  = csr_wdata;
               CSR_RICH_YELLOW:       rich_yel  = csr_wdata;
               CSR_RICH_KEY:          rich_key  = csr_wdata;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            item.red   = req_tdata[7:0];
            item.green = req_tdata[15:8];
            item.blue  = req_tdata[23:16];
            item.cmyk  = predict_cmyk(item.red, item.green, item.blue);
            expected_cmyk_q.insert(expected_cmyk_q.size(), item);
         end

         if (rsp_tvalid && rsp_tready) begin
            got  = cmyk_type'(rsp_tdata[59:0]);
            fill = rsp_tdata[63:60];
            results_seen++;
            if (expected_cmyk_q.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("result %0d with no pixel pending: c=%0d m=%0d y=%0d k=%0d",
                           results_seen, got.cyan, got.magenta, got.yellow, got.key);
               errors++;
            end else begin
               exp_item = expected_cmyk_q.pop_front();
               if (got !== exp_item.cmyk || fill !== 4'h0) begin
                  if (errors < MAX_REPORTS) begin
                     $display("result %0d for rgb %0d,%0d,%0d: expected c=%0d m=%0d y=%0d k=%0d",
                              results_seen, exp_item.red, exp_item.green, exp_item.blue,
                              exp_item.cmyk.cyan, exp_item.cmyk.magenta,
                              exp_item.cmyk.yellow, exp_item.cmyk.key);
                     $display("   got c=%0d m=%0d y=%0d k=%0d fill=%h",
                              got.cyan, got.magenta, got.yellow, got.key, fill);
                  end
                  errors++;
               end
            end
         end
      end
      pending_count  <= expected_cmyk_q.size();
      mismatch_count <= errors;
   end

endmodule

/* dv/tb_rgb_to_cmyk_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_cmyk_converter_top
// Drives pixels and rich black settings into the rgb to cmyk block, with
// random gaps on the pixel side and random stalls on the result side.
// Directed corner pixels come first, then random phases under varied
// register settings; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_rgb_to_cmyk_converter_top;
   import rtc_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_PAUSE   = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 240;
   localparam logic [PCT_W-1:0]     PCT_MAX          = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_RICH_KEY + 1'b1;

   typedef enum int {IDLE_NONE, IDLE_BURSTY} idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [23:0]          req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [63:0]          rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PCT_W-1:0]     csr_wdata;

   int            mismatch_count;
   int            pending_count;
   int            cycle_count   = 0;
   int            pixels_sent   = 0;
   int            black_sent    = 0;
   int            csr_writes    = 0;
   int            settings_used = 0;
   idle_mode_type idle_mode     = IDLE_BURSTY;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   rgb_to_cmyk_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rgb_to_cmyk_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap(idle_mode_type mode);
      int roll;
      if (mode == IDLE_NONE) return 0;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // rich value with weight on the extremes, including above full scale
   function automatic logic [PCT_W-1:0] pick_pct();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) return '0;
      if (roll < 45) return FULL_SCALE;
      if (roll < 60) return PCT_MAX;
      return PCT_W'($urandom);
   endfunction

   task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      int gap;
      gap = pick_gap(idle_mode);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      if (r == 0 && g == 0 && b == 0) black_sent++;
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [PCT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic apply_setting(logic [PCT_W-1:0] en_word, logic [PCT_W-1:0] c,
                                logic [PCT_W-1:0] m, logic [PCT_W-1:0] y,
                                logic [PCT_W-1:0] k, bit with_unused);
      if (with_unused)
         write_csr(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(2)), PCT_W'($urandom));
      write_csr(CSR_RICH_BLACK_ENABLE, en_word);
      write_csr(CSR_RICH_CYAN, c);
      write_csr(CSR_RICH_MAGENTA, m);
      write_csr(CSR_RICH_YELLOW, y);
      write_csr(CSR_RICH_KEY, k);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // block is idle once every prediction is matched and the pipe has settled
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // result side ready with random stalls
   initial begin : result_ready
      int run_len;
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         run_len = $urandom_range(12, 1);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall = pick_gap(idle_mode);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_count);
      $display("Test completed with failures");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      logic [CHAN_W-1:0] r, g, b;
      logic [PCT_W-1:0]  en_word;
      int                roll;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: plain black, white, primaries, near-black
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd253);
      send_pixel(8'd128, 8'd64, 8'd32);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd254);
      send_pixel(8'd170, 8'd85, 8'd0);
      wait_drained();

      // rich black on, other registers still at reset values
      write_csr(CSR_RICH_BLACK_ENABLE, PCT_W'(1));
      csr_we <= 1'b0;
      settings_used++;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd3, 8'd2, 8'd1);
      wait_drained();

      // rich cyan above full scale, enable with all upper bits set
      apply_setting(PCT_MAX, PCT_MAX, '0, FULL_SCALE, '0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd10, 8'd20, 8'd30);
      send_pixel(8'd0, 8'd0, 8'd0);
      wait_drained();

      // enable word with low bit clear turns rich black off
      apply_setting(PCT_MAX - 1'b1, '0, PCT_MAX, PCT_W'(12345), PCT_MAX, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd128, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      wait_drained();

      // random phases, each under its own setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_mode = (ph == 0) ? IDLE_NONE : IDLE_BURSTY;
         en_word = PCT_W'($urandom);
         if (ph == 0) en_word[0] = 1'b1;
         else if (ph == 1) en_word[0] = 1'b0;
         else en_word[0] = ($urandom_range(3) != 0);
         if (ph == 2)
            apply_setting(en_word, '0, '0, '0, '0, 1'b0);
         else if (ph == RANDOM_PHASES - 1)
            apply_setting(en_word, PCT_MAX, PCT_MAX, PCT_MAX, PCT_MAX, 1'b1);
         else
            apply_setting(en_word, pick_pct(), pick_pct(), pick_pct(), pick_pct(),
                          1'($urandom_range(1)));

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            r = CHAN_W'($urandom);
            g = CHAN_W'($urandom);
            b = CHAN_W'($urandom);
            if (roll < 8) begin
               // pure black
               r = '0;
               g = '0;
               b = '0;
            end else if (roll < 14) begin
               // gray
               g = r;
               b = r;
            end else if (roll < 26) begin
               // channels at the extremes, one sometimes left random
               r = $urandom_range(1) ? CHAN_MAX : '0;
               g = $urandom_range(1) ? CHAN_MAX : '0;
               if ($urandom_range(1)) b = $urandom_range(1) ? CHAN_MAX : '0;
            end else if (roll < 36) begin
               // very dark pixels, small divisor
               r = CHAN_W'($urandom_range(3));
               g = CHAN_W'($urandom_range(3));
               b = CHAN_W'($urandom_range(3));
            end else if (roll < 46) begin
               // red and green equal, sharing the maximum unless blue is larger
               g = r;
            end
            send_pixel(r, g, b);
         end
         wait_drained();
      end

      $display("%0d pixels converted (%0d pure black) under %0d register settings",
               pixels_sent, black_sent, settings_used);
      $display("%0d register writes, %0d cycles, %0d mismatches",
               csr_writes, cycle_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
